// ----- design/gfc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfc_pkg: shared types and constants of the glitch fire controller
// Command and result layouts, phase codes, error codes and commit limits.
// ----------------------------------------------------------------------------
package gfc_pkg;

  // commit limits
  localparam int WIDTH_MIN_NS_DEF = 8;
  localparam int WIDTH_MAX_NS_DEF = 50000;
  localparam int DELAY_MAX_US_DEF = 1000000;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 20;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 80;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_MODE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_SELECT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PULSE_WIDTH   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DELAY         = 2'd3;

  // command codes
  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_COMMIT = 3'd1;
  localparam logic [2:0] MODE_ARM    = 3'd2;
  localparam logic [2:0] MODE_FIRE   = 3'd3;
  localparam logic [2:0] MODE_DISARM = 3'd4;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_BAD_CONFIG = 3'd1;
  localparam logic [2:0] ERR_NO_PATH    = 3'd2;
  localparam logic [2:0] ERR_ENGINE     = 3'd3;
  localparam logic [2:0] ERR_TIMEOUT    = 3'd4;

  // output path codes
  localparam logic [1:0] OUT_LOW_POWER  = 2'd1;
  localparam logic [1:0] OUT_HIGH_POWER = 2'd2;

  // reported phase codes
  localparam logic [2:0] CODE_IDLE    = 3'd0;
  localparam logic [2:0] CODE_ARMED   = 3'd1;
  localparam logic [2:0] CODE_WAITING = 3'd2;
  localparam logic [2:0] CODE_FIRED   = 3'd3;
  localparam logic [2:0] CODE_ERROR   = 3'd4;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_ARMED   = 5'b00010,
    PH_WAITING = 5'b00100,
    PH_FIRED   = 5'b01000,
    PH_ERROR   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [19:0] pulse_delay;
    logic [15:0] pulse_width_ns;
    logic [1:0]  output_select;
    logic [1:0]  trigger_mode;
  } settings_t;

  typedef struct packed {
    logic [31:0] at_ms;
    logic [1:0]  outp;
    logic [19:0] delay;
    logic [15:0] width;
  } fire_rec_t;

  // last field in the lowest bits
  typedef struct packed {
    logic        engine_fault;
    logic        engine_done;
    logic [31:0] timeout_ms;
    logic [31:0] now_ms;
    logic [2:0]  mode;
  } cmd_t;

  typedef struct packed {
    logic [31:0] fired_at_ms;
    logic [1:0]  fired_output;
    logic [19:0] fired_delay_us;
    logic [15:0] fired_width_ns;
    logic        engine_stop;
    logic        engine_start;
    logic        force_gate_off;
    logic [2:0]  error_code;
    logic [2:0]  state_now;
    logic        accepted;
  } result_t;

  function automatic logic [2:0] phase_code(phase_t ph);
    logic [2:0] code;
    unique case (ph)
      PH_IDLE:    code = CODE_IDLE;
      PH_ARMED:   code = CODE_ARMED;
      PH_WAITING: code = CODE_WAITING;
      PH_FIRED:   code = CODE_FIRED;
      PH_ERROR:   code = CODE_ERROR;
      default:    code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ----- design/gfc_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfc_core: command state machine of the glitch fire controller
// Holds phase, error, committed settings, wait timer and fire record; works
// out the result of one command and updates its state when the command is
// taken.
// ----------------------------------------------------------------------------
module gfc_core #(
  parameter int WIDTH_MIN_NS = gfc_pkg::WIDTH_MIN_NS_DEF,
  parameter int WIDTH_MAX_NS = gfc_pkg::WIDTH_MAX_NS_DEF,
  parameter int DELAY_MAX_US = gfc_pkg::DELAY_MAX_US_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  gfc_pkg::cmd_t       cmd,
  input  gfc_pkg::settings_t  regs,
  output gfc_pkg::result_t    res
);

  gfc_pkg::phase_t    phase, phase_next;
  logic [2:0]         error_reg, error_next;
  logic               settings_valid, settings_valid_next;
  gfc_pkg::settings_t committed, committed_next;
  logic [31:0]        start_time, start_time_next;
  logic [31:0]        wait_limit, wait_limit_next;
  gfc_pkg::fire_rec_t fire_record, fire_record_next;

  logic        ok, start, stop, gate_off;
  logic        regs_pass, path_ok;
  logic [31:0] elapsed;

  always_comb begin
    regs_pass = (regs.output_select == gfc_pkg::OUT_LOW_POWER ||
                 regs.output_select == gfc_pkg::OUT_HIGH_POWER) &&
                (regs.pulse_width_ns >= 16'(WIDTH_MIN_NS)) &&
                (regs.pulse_width_ns <= 16'(WIDTH_MAX_NS)) &&
                (regs.pulse_delay <= 20'(DELAY_MAX_US));
    path_ok = committed.output_select == gfc_pkg::OUT_LOW_POWER ||
              committed.output_select == gfc_pkg::OUT_HIGH_POWER;
    elapsed = cmd.now_ms - start_time;

    phase_next          = phase;
    error_next          = error_reg;
    settings_valid_next = settings_valid;
    committed_next      = committed;
    start_time_next     = start_time;
    wait_limit_next     = wait_limit;
    fire_record_next    = fire_record;
    ok       = 1'b0;
    start    = 1'b0;
    stop     = 1'b0;
    gate_off = 1'b0;

    unique case (cmd.mode)
      gfc_pkg::MODE_TICK: begin
        ok = 1'b1;
        if (phase == gfc_pkg::PH_WAITING) begin
          if (cmd.engine_done) begin
            fire_record_next.width = committed.pulse_width_ns;
            fire_record_next.delay = committed.pulse_delay;
            fire_record_next.outp  = committed.output_select;
            fire_record_next.at_ms = cmd.now_ms;
            stop       = 1'b1;
            gate_off   = 1'b1;
            phase_next = gfc_pkg::PH_FIRED;
          end else if (wait_limit != 32'd0 && elapsed > wait_limit) begin
            stop       = 1'b1;
            gate_off   = 1'b1;
            phase_next = gfc_pkg::PH_ERROR;
            error_next = gfc_pkg::ERR_TIMEOUT;
          end
        end
      end
      gfc_pkg::MODE_COMMIT: begin
        if (regs_pass) begin
          committed_next      = regs;
          settings_valid_next = 1'b1;
          phase_next          = gfc_pkg::PH_IDLE;
          error_next          = gfc_pkg::ERR_NONE;
          ok                  = 1'b1;
        end
      end
      gfc_pkg::MODE_ARM: begin
        if (!settings_valid) begin
          stop       = 1'b1;
          gate_off   = 1'b1;
          phase_next = gfc_pkg::PH_ERROR;
          error_next = gfc_pkg::ERR_BAD_CONFIG;
        end else if (phase == gfc_pkg::PH_IDLE || phase == gfc_pkg::PH_FIRED) begin
          gate_off   = 1'b1;
          phase_next = gfc_pkg::PH_ARMED;
          error_next = gfc_pkg::ERR_NONE;
          ok         = 1'b1;
        end
      end
      gfc_pkg::MODE_FIRE: begin
        if (phase == gfc_pkg::PH_ARMED) begin
          gate_off = 1'b1;
          if (!path_ok) begin
            stop       = 1'b1;
            phase_next = gfc_pkg::PH_ERROR;
            error_next = gfc_pkg::ERR_NO_PATH;
          end else begin
            // the start request goes out even when the engine reports a fault
            start = 1'b1;
            if (cmd.engine_fault) begin
              stop       = 1'b1;
              phase_next = gfc_pkg::PH_ERROR;
              error_next = gfc_pkg::ERR_ENGINE;
            end else begin
              start_time_next = cmd.now_ms;
              wait_limit_next = cmd.timeout_ms;
              phase_next      = gfc_pkg::PH_WAITING;
              error_next      = gfc_pkg::ERR_NONE;
              ok              = 1'b1;
            end
          end
        end
      end
      gfc_pkg::MODE_DISARM: begin
        stop             = 1'b1;
        gate_off         = 1'b1;
        phase_next       = gfc_pkg::PH_IDLE;
        error_next       = gfc_pkg::ERR_NONE;
        fire_record_next = '0;
        ok               = 1'b1;
      end
      default: begin
      end
    endcase

    res.accepted       = ok;
    res.state_now      = gfc_pkg::phase_code(phase_next);
    res.error_code     = error_next;
    res.force_gate_off = gate_off;
    res.engine_start   = start;
    res.engine_stop    = stop;
    res.fired_width_ns = fire_record_next.width;
    res.fired_delay_us = fire_record_next.delay;
    res.fired_output   = fire_record_next.outp;
    res.fired_at_ms    = fire_record_next.at_ms;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= gfc_pkg::PH_IDLE;
      error_reg      <= gfc_pkg::ERR_NONE;
      settings_valid <= 1'b0;
      committed      <= '0;
      start_time     <= '0;
      wait_limit     <= '0;
      fire_record    <= '0;
    end else if (cmd_valid) begin
      phase          <= phase_next;
      error_reg      <= error_next;
      settings_valid <= settings_valid_next;
      committed      <= committed_next;
      start_time     <= start_time_next;
      wait_limit     <= wait_limit_next;
      fire_record    <= fire_record_next;
    end
  end

  // the error register is set exactly while the phase is error
  a_error_matches_phase: assert property (@(posedge clk) disable iff (rst)
    (phase == gfc_pkg::PH_ERROR) == (error_reg != gfc_pkg::ERR_NONE))
    else $error("error register out of step with phase");

  // waiting is reachable only with committed settings
  a_waiting_has_settings: assert property (@(posedge clk) disable iff (rst)
    (phase == gfc_pkg::PH_WAITING) |-> settings_valid)
    else $error("waiting without valid settings");

  // a start request leaves the block waiting or in error
  a_start_outcome: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && res.engine_start) |=>
      (phase == gfc_pkg::PH_WAITING || phase == gfc_pkg::PH_ERROR))
    else $error("engine start without waiting or error");

  // disarm clears the fire record
  a_disarm_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd.mode == gfc_pkg::MODE_DISARM) |=>
      (fire_record == '0 && phase == gfc_pkg::PH_IDLE))
    else $error("disarm left a fire record or a phase other than idle");

endmodule

// ----- design/glitch_fire_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glitch_fire_controller: command controller for a crowbar glitch pulse
// Commands (tick, commit, arm, fire, disarm) arrive on the s_axis stream; one
// result per command leaves on the m_axis stream. Settings are written over
// a plain write port (cfg_wr_en, cfg_addr, cfg_wr_data) only while idle, a user
// rule that the block does not enforce; a commit command checks and latches them.
// Each result is registered in the output register that drives m_axis.
// Throughput: one command per cycle while s_axis_tready is high; the state
// update is a single pass of logic from the command port to the result register.
// When m_axis stalls, one more request is held in a skid register, after which
// s_axis_tready drops until the output drains.
// Reset (rst, synchronous): phase idle, no error, no valid settings, setting
// registers, timer and fire record zero, both result registers empty.
// ----------------------------------------------------------------------------
module glitch_fire_controller #(
  parameter int WIDTH_MIN_NS = gfc_pkg::WIDTH_MIN_NS_DEF,
  parameter int WIDTH_MAX_NS = gfc_pkg::WIDTH_MAX_NS_DEF,
  parameter int DELAY_MAX_US = gfc_pkg::DELAY_MAX_US_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [gfc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [gfc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // mode[2:0], now_ms[34:3], timeout_ms[66:35], engine_done[67],
  // engine_fault[68], zero fill[71:69]
  input  logic [gfc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // accepted[0], state_now[3:1], error_code[6:4], force_gate_off[7],
  // engine_start[8], engine_stop[9], fired_width_ns[25:10],
  // fired_delay_us[45:26], fired_output[47:46], fired_at_ms[79:48]
  output logic [gfc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  gfc_pkg::settings_t regs;
  gfc_pkg::cmd_t      cmd;
  gfc_pkg::result_t   res;
  gfc_pkg::result_t   out_data, skid_data;
  logic               out_valid, skid_valid;
  logic               in_fire, out_free;

  assign cmd = gfc_pkg::cmd_t'(s_axis_tdata[$bits(gfc_pkg::cmd_t)-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        gfc_pkg::REG_TRIGGER_MODE:  regs.trigger_mode   <= cfg_wr_data[1:0];
        gfc_pkg::REG_OUTPUT_SELECT: regs.output_select  <= cfg_wr_data[1:0];
        gfc_pkg::REG_PULSE_WIDTH:   regs.pulse_width_ns <= cfg_wr_data[15:0];
        gfc_pkg::REG_DELAY:         regs.pulse_delay    <= cfg_wr_data[19:0];
        default: begin
        end
      endcase
    end
  end

  gfc_core #(
    .WIDTH_MIN_NS (WIDTH_MIN_NS),
    .WIDTH_MAX_NS (WIDTH_MAX_NS),
    .DELAY_MAX_US (DELAY_MAX_US)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (in_fire),
    .cmd       (cmd),
    .regs      (regs),
    .res       (res)
  );

  assign s_axis_tready = !skid_valid;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  // output register can load this cycle
  assign out_free      = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_fire) begin
        out_data <= res;
      end
    end else if (in_fire) begin
      skid_data <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

// ----- verif/tb_glitch_fire_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glitch_fire_controller: self-checking bench for the glitch fire controller
// Drives command requests on s_axis and settings on the write port, predicts
// each result from a cycle-free model of the phase machine and compares it
// field by field with m_axis. Both stream sides idle at random; one long
// receiver hold backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_glitch_fire_controller;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;
  localparam int CFG_W = gfc_pkg::CFG_DATA_W;
  localparam logic [2:0] MODE_RESERVED = 3'd7;

  // keeps the expected results and its own copy of the controller state
  class fire_scoreboard;
    gfc_pkg::settings_t staged;
    gfc_pkg::settings_t committed;
    logic [2:0]         phase;
    logic [2:0]         err;
    bit                 settings_ok;
    logic [31:0]        start_ms;
    logic [31:0]        limit_ms;
    gfc_pkg::fire_rec_t record;
    gfc_pkg::result_t   outcome_q[$];
    int                 errors;

    function new();
      staged = '0;
      committed = '0;
      phase = gfc_pkg::CODE_IDLE;
      err = gfc_pkg::ERR_NONE;
      settings_ok = 1'b0;
      start_ms = '0;
      limit_ms = '0;
      record = '0;
      errors = 0;
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    function void write_reg(logic [gfc_pkg::CFG_ADDR_W-1:0] idx,
                            logic [gfc_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        gfc_pkg::REG_TRIGGER_MODE:  staged.trigger_mode = data[1:0];
        gfc_pkg::REG_OUTPUT_SELECT: staged.output_select = data[1:0];
        gfc_pkg::REG_PULSE_WIDTH:   staged.pulse_width_ns = data[15:0];
        gfc_pkg::REG_DELAY:         staged.pulse_delay = data[19:0];
        default: ;
      endcase
    endfunction

    function void note_command(gfc_pkg::cmd_t c);
      gfc_pkg::result_t r;
      logic [31:0]      elapsed;
      bit               ok;
      bit               gate_off;
      bit               stop_eng;
      bit               start_eng;
      ok = 1'b0;
      gate_off = 1'b0;
      stop_eng = 1'b0;
      start_eng = 1'b0;
      case (c.mode)
        gfc_pkg::MODE_TICK: begin
          ok = 1'b1;
          elapsed = c.now_ms - start_ms;
          if (phase == gfc_pkg::CODE_WAITING) begin
            // done beats the timeout
            if (c.engine_done) begin
              record.width = committed.pulse_width_ns;
              record.delay = committed.pulse_delay;
              record.outp = committed.output_select;
              record.at_ms = c.now_ms;
              stop_eng = 1'b1;
              gate_off = 1'b1;
              phase = gfc_pkg::CODE_FIRED;
            end else if (limit_ms != 0 && elapsed > limit_ms) begin
              stop_eng = 1'b1;
              gate_off = 1'b1;
              phase = gfc_pkg::CODE_ERROR;
              err = gfc_pkg::ERR_TIMEOUT;
            end
          end
        end
        gfc_pkg::MODE_COMMIT: begin
          if ((staged.output_select == gfc_pkg::OUT_LOW_POWER ||
               staged.output_select == gfc_pkg::OUT_HIGH_POWER) &&
              staged.pulse_width_ns >= gfc_pkg::WIDTH_MIN_NS_DEF &&
              staged.pulse_width_ns <= gfc_pkg::WIDTH_MAX_NS_DEF &&
              staged.pulse_delay <= gfc_pkg::DELAY_MAX_US_DEF) begin
            committed = staged;
            settings_ok = 1'b1;
            phase = gfc_pkg::CODE_IDLE;
            err = gfc_pkg::ERR_NONE;
            ok = 1'b1;
          end
        end
        gfc_pkg::MODE_ARM: begin
          if (!settings_ok) begin
            stop_eng = 1'b1;
            gate_off = 1'b1;
            phase = gfc_pkg::CODE_ERROR;
            err = gfc_pkg::ERR_BAD_CONFIG;
          end else if (phase == gfc_pkg::CODE_IDLE || phase == gfc_pkg::CODE_FIRED) begin
            gate_off = 1'b1;
            phase = gfc_pkg::CODE_ARMED;
            err = gfc_pkg::ERR_NONE;
            ok = 1'b1;
          end
        end
        gfc_pkg::MODE_FIRE: begin
          if (phase == gfc_pkg::CODE_ARMED) begin
            gate_off = 1'b1;
            if (committed.output_select != gfc_pkg::OUT_LOW_POWER &&
                committed.output_select != gfc_pkg::OUT_HIGH_POWER) begin
              stop_eng = 1'b1;
              phase = gfc_pkg::CODE_ERROR;
              err = gfc_pkg::ERR_NO_PATH;
            end else begin
              // the start attempt is visible even when the engine faults
              start_eng = 1'b1;
              if (c.engine_fault) begin
                stop_eng = 1'b1;
                phase = gfc_pkg::CODE_ERROR;
                err = gfc_pkg::ERR_ENGINE;
              end else begin
                start_ms = c.now_ms;
                limit_ms = c.timeout_ms;
                phase = gfc_pkg::CODE_WAITING;
                err = gfc_pkg::ERR_NONE;
                ok = 1'b1;
              end
            end
          end
        end
        gfc_pkg::MODE_DISARM: begin
          stop_eng = 1'b1;
          gate_off = 1'b1;
          phase = gfc_pkg::CODE_IDLE;
          err = gfc_pkg::ERR_NONE;
          record = '0;
          ok = 1'b1;
        end
        default: ;
      endcase
      r.accepted = ok;
      r.state_now = phase;
      r.error_code = err;
      r.force_gate_off = gate_off;
      r.engine_start = start_eng;
      r.engine_stop = stop_eng;
      r.fired_width_ns = record.width;
      r.fired_delay_us = record.delay;
      r.fired_output = record.outp;
      r.fired_at_ms = record.at_ms;
      outcome_q.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_outcome(gfc_pkg::result_t act);
      gfc_pkg::result_t exp_r;
      if (outcome_q.size() == 0) begin
        $error("result with no pending request: %0h", act);
        errors++;
        return;
      end
      exp_r = outcome_q.pop_front();
      compare("accepted", 32'(exp_r.accepted), 32'(act.accepted));
      compare("state_now", 32'(exp_r.state_now), 32'(act.state_now));
      compare("error_code", 32'(exp_r.error_code), 32'(act.error_code));
      compare("force_gate_off", 32'(exp_r.force_gate_off), 32'(act.force_gate_off));
      compare("engine_start", 32'(exp_r.engine_start), 32'(act.engine_start));
      compare("engine_stop", 32'(exp_r.engine_stop), 32'(act.engine_stop));
      compare("fired_width_ns", 32'(exp_r.fired_width_ns), 32'(act.fired_width_ns));
      compare("fired_delay_us", 32'(exp_r.fired_delay_us), 32'(act.fired_delay_us));
      compare("fired_output", 32'(exp_r.fired_output), 32'(act.fired_output));
      compare("fired_at_ms", exp_r.fired_at_ms, act.fired_at_ms);
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_wr_en = 1'b0;
  logic [gfc_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [gfc_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [gfc_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [gfc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  fire_scoreboard sb = new();
  int unsigned    cycle_count = 0;
  int             issued = 0;
  bit             idle_on = 1'b1;
  bit             hold_req = 1'b0;
  logic [31:0]    clock_ms = '0;

  glitch_fire_controller dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_addr     (cfg_addr),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // values read here are the ones from before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_outcome(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_command(s_axis_tdata[$bits(gfc_pkg::cmd_t)-1:0]);
    end
  end

  // result side: random stall per result, one long hold on request
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = idle_on ? $urandom_range(0, 17) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  function automatic gfc_pkg::cmd_t cmd_of(logic [2:0] mode, logic [31:0] tmo,
                                           logic done, logic fault);
    gfc_pkg::cmd_t c;
    c.mode = mode;
    c.now_ms = clock_ms;
    c.timeout_ms = tmo;
    c.engine_done = done;
    c.engine_fault = fault;
    return c;
  endfunction

  // valid stays high across back-to-back requests
  task automatic issue(gfc_pkg::cmd_t c);
    int gap;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(gfc_pkg::IN_DATA_W - $bits(gfc_pkg::cmd_t)){1'b0}}, c};
    do @(posedge clk); while (!s_axis_tready);
    issued++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_settings(gfc_pkg::settings_t s);
    cfg_wr_en <= 1'b1;
    cfg_addr <= gfc_pkg::REG_TRIGGER_MODE;
    cfg_wr_data <= CFG_W'(s.trigger_mode);
    @(posedge clk);
    sb.write_reg(gfc_pkg::REG_TRIGGER_MODE, CFG_W'(s.trigger_mode));
    cfg_addr <= gfc_pkg::REG_OUTPUT_SELECT;
    cfg_wr_data <= CFG_W'(s.output_select);
    @(posedge clk);
    sb.write_reg(gfc_pkg::REG_OUTPUT_SELECT, CFG_W'(s.output_select));
    cfg_addr <= gfc_pkg::REG_PULSE_WIDTH;
    cfg_wr_data <= CFG_W'(s.pulse_width_ns);
    @(posedge clk);
    sb.write_reg(gfc_pkg::REG_PULSE_WIDTH, CFG_W'(s.pulse_width_ns));
    cfg_addr <= gfc_pkg::REG_DELAY;
    cfg_wr_data <= s.pulse_delay;
    @(posedge clk);
    sb.write_reg(gfc_pkg::REG_DELAY, s.pulse_delay);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic gfc_pkg::settings_t pick_settings(int p);
    gfc_pkg::settings_t s;
    s.trigger_mode = 2'($urandom_range(0, 3));
    s.output_select = 2'($urandom_range(1, 2));
    s.pulse_width_ns = 16'($urandom_range(gfc_pkg::WIDTH_MIN_NS_DEF,
                                          gfc_pkg::WIDTH_MAX_NS_DEF));
    s.pulse_delay = 20'($urandom_range(0, gfc_pkg::DELAY_MAX_US_DEF));
    case (p)
      0: begin
        s.trigger_mode = 2'd0;
        s.output_select = gfc_pkg::OUT_LOW_POWER;
        s.pulse_width_ns = 16'(gfc_pkg::WIDTH_MIN_NS_DEF);
        s.pulse_delay = '0;
      end
      1: begin
        s.trigger_mode = 2'd3;
        s.output_select = 2'd3;
        s.pulse_width_ns = 16'hFFFF;
        s.pulse_delay = 20'hFFFFF;
      end
      2: s.pulse_width_ns = 16'(gfc_pkg::WIDTH_MIN_NS_DEF - 1);
      default: begin
        case ($urandom_range(0, 9))
          0: s.output_select = 2'd0;
          1: s.output_select = 2'd3;
          2: s.pulse_width_ns = 16'(gfc_pkg::WIDTH_MAX_NS_DEF + 1);
          3: s.pulse_delay = 20'(gfc_pkg::DELAY_MAX_US_DEF + 1);
          4: s.pulse_width_ns = 16'($urandom_range(0, gfc_pkg::WIDTH_MIN_NS_DEF - 1));
          default: ;
        endcase
      end
    endcase
    return s;
  endfunction

  // mostly commit/arm/fire/tick runs, some random noise in between
  task automatic run_phase(int n_items);
    int            stop_at;
    int            n_ticks;
    int            noise;
    logic [31:0]   tmo;
    gfc_pkg::cmd_t c;
    stop_at = issued + n_items;
    while (issued < stop_at) begin
      if ($urandom_range(0, 9) < 8) begin
        case ($urandom_range(0, 7))
          0: clock_ms = $urandom;
          1: clock_ms = 32'hFFFF_FFC0;
          default: ;
        endcase
        if ($urandom_range(0, 3) == 0)
          issue(cmd_of(gfc_pkg::MODE_COMMIT, $urandom, 1'($urandom), 1'($urandom)));
        issue(cmd_of(gfc_pkg::MODE_ARM, $urandom, 1'($urandom), 1'($urandom)));
        case ($urandom_range(0, 5))
          0: tmo = '0;
          1: tmo = $urandom;
          default: tmo = $urandom_range(1, 60);
        endcase
        issue(cmd_of(gfc_pkg::MODE_FIRE, tmo, 1'($urandom), $urandom_range(0, 7) == 0));
        n_ticks = $urandom_range(0, 6);
        repeat (n_ticks) begin
          clock_ms += $urandom_range(0, 25);
          issue(cmd_of(gfc_pkg::MODE_TICK, $urandom, 1'b0, 1'($urandom)));
        end
        clock_ms += $urandom_range(0, 25);
        issue(cmd_of(gfc_pkg::MODE_TICK, $urandom, $urandom_range(0, 3) != 0,
                     1'($urandom)));
        if ($urandom_range(0, 3) == 0)
          issue(cmd_of(gfc_pkg::MODE_DISARM, $urandom, 1'($urandom), 1'($urandom)));
      end else begin
        noise = $urandom_range(1, 4);
        repeat (noise) begin
          c.mode = 3'($urandom_range(0, 7));
          c.now_ms = $urandom;
          c.timeout_ms = $urandom;
          c.engine_done = 1'($urandom);
          c.engine_fault = 1'($urandom);
          issue(c);
        end
      end
    end
  endtask

  initial begin
    gfc_pkg::settings_t s;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // nothing committed yet
    issue(cmd_of(gfc_pkg::MODE_TICK, '0, 1'b1, 1'b0));
    issue(cmd_of(gfc_pkg::MODE_FIRE, '0, 1'b0, 1'b0));
    issue(cmd_of(gfc_pkg::MODE_ARM, '0, 1'b0, 1'b0));
    issue(cmd_of(MODE_RESERVED, 32'hFFFF_FFFF, 1'b1, 1'b1));
    issue(cmd_of(gfc_pkg::MODE_COMMIT, '0, 1'b0, 1'b0));
    issue(cmd_of(gfc_pkg::MODE_DISARM, '0, 1'b0, 1'b0));
    drain();

    s.trigger_mode = 2'd3;
    s.output_select = gfc_pkg::OUT_HIGH_POWER;
    s.pulse_width_ns = 16'(gfc_pkg::WIDTH_MAX_NS_DEF);
    s.pulse_delay = 20'(gfc_pkg::DELAY_MAX_US_DEF);
    load_settings(s);
    issue(cmd_of(gfc_pkg::MODE_COMMIT, '0, 1'b0, 1'b0));
    issue(cmd_of(gfc_pkg::MODE_FIRE, '0, 1'b0, 1'b0));
    issue(cmd_of(gfc_pkg::MODE_ARM, '0, 1'b0, 1'b0));
    issue(cmd_of(gfc_pkg::MODE_ARM, '0, 1'b0, 1'b0));
    issue(cmd_of(gfc_pkg::MODE_FIRE, '0, 1'b0, 1'b1));
    issue(cmd_of(gfc_pkg::MODE_ARM, '0, 1'b0, 1'b0));
    issue(cmd_of(gfc_pkg::MODE_COMMIT, '0, 1'b0, 1'b0));
    // elapsed across the wrap: equal to the limit holds, one more times out
    issue(cmd_of(gfc_pkg::MODE_ARM, '0, 1'b0, 1'b0));
    clock_ms = 32'hFFFF_FFF0;
    issue(cmd_of(gfc_pkg::MODE_FIRE, 32'd16, 1'b0, 1'b0));
    clock_ms = 32'd0;
    issue(cmd_of(gfc_pkg::MODE_TICK, '0, 1'b0, 1'b0));
    clock_ms = 32'd1;
    issue(cmd_of(gfc_pkg::MODE_TICK, '0, 1'b0, 1'b0));
    // zero timeout waits forever, then done completes the fire
    issue(cmd_of(gfc_pkg::MODE_COMMIT, '0, 1'b0, 1'b0));
    issue(cmd_of(gfc_pkg::MODE_ARM, '0, 1'b0, 1'b0));
    issue(cmd_of(gfc_pkg::MODE_FIRE, '0, 1'b0, 1'b0));
    clock_ms = clock_ms - 1;
    issue(cmd_of(gfc_pkg::MODE_TICK, '0, 1'b0, 1'b1));
    issue(cmd_of(gfc_pkg::MODE_TICK, '0, 1'b1, 1'b1));
    // re-arm from fired; done and timeout together
    issue(cmd_of(gfc_pkg::MODE_ARM, '0, 1'b0, 1'b0));
    issue(cmd_of(gfc_pkg::MODE_FIRE, 32'd1, 1'b0, 1'b0));
    clock_ms += 100;
    issue(cmd_of(gfc_pkg::MODE_TICK, '0, 1'b1, 1'b0));
    issue(cmd_of(gfc_pkg::MODE_DISARM, '0, 1'b0, 1'b0));

    for (int p = 0; p < 12; p++) begin
      drain();
      load_settings(pick_settings(p));
      idle_on = (p % 4 != 2);
      if (p == 5) begin
        idle_on = 1'b0;
        hold_req = 1'b1;
      end
      run_phase(112);
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
design/gfc_pkg.sv
design/gfc_core.sv
design/glitch_fire_controller.sv
verif/tb_glitch_fire_controller.sv
